// ===== design/thnm_pkg.sv =====
package thnm_pkg;

  // Field widths fixed by the interface.
  localparam int ROW_W  = 6;
  localparam int BITS_W = 64;
  localparam int CNT_W  = 7;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RDI   = 5'b00010,
    S_LATI  = 5'b00100,
    S_SWEEP = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

endpackage

// ===== design/two_hop_nonneighbor_matrix.sv =====
// Channel  | Handshake          | Payload
// ---------+--------------------+-------------------------------------------
// input    | in_valid/in_ready  | row_index, row_bits, last_row
// output   | out_valid/out_ready| out_row_index, out_row_bits, last_out
// config   | cfg_we             | cfg_data (node_count)
//
// A row without last_row is stored and produces no result.
// After the last row, each result row i takes a sweep over all N stored rows
// through the single read port of the adjacency memory, and then waits for
// out_ready.
// Synchronous active-high reset returns to idle with node_count = 64.
// in_ready is low from the last row until the final result row is taken.
module two_hop_nonneighbor_matrix #(
  parameter int MAX_NODES = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [thnm_pkg::CNT_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [thnm_pkg::ROW_W-1:0]   row_index,
  input  logic [thnm_pkg::BITS_W-1:0]  row_bits,
  input  logic                         last_row,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [thnm_pkg::ROW_W-1:0]   out_row_index,
  output logic [thnm_pkg::BITS_W-1:0]  out_row_bits,
  output logic                         last_out
);
  import thnm_pkg::*;

  localparam int AW = $clog2(MAX_NODES);

  state_t              state;
  logic [CNT_W-1:0]    node_count;
  logic [CNT_W-1:0]    n_act;
  logic [CNT_W-1:0]    n_sel;
  logic [ROW_W-1:0]    n_last;
  logic [BITS_W-1:0]   mask;
  logic [BITS_W-1:0]   ri;
  logic [BITS_W-1:0]   acc;
  logic [ROW_W-1:0]    i;
  logic [CNT_W-1:0]    k;
  logic [ROW_W-1:0]    kd;
  logic                pv;
  logic [AW-1:0]       rd_addr;
  logic [BITS_W-1:0]   rd_data;
  logic [BITS_W-1:0]   adj_mem [MAX_NODES];
  logic                in_acc;
  logic                out_acc;
  logic                wr_en;

  // Shared pair unit signals.
  logic [BITS_W-1:0]   rk;
  logic [BITS_W-1:0]   common;
  logic [BITS_W-1:0]   onehot_i;
  logic [BITS_W-1:0]   onehot_k;
  logic                t_ik;
  logic                t_ki;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign wr_en   = in_acc && ({1'b0, row_index} < CNT_W'(MAX_NODES));

  // Node count register; a running computation works from its latched copy.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CNT_W'(64);
    end else if (cfg_we) begin
      node_count <= cfg_data;
    end
  end

  // Clamp the node count into the supported range.
  always_comb begin
    if (node_count == '0) begin
      n_sel = CNT_W'(1);
    end else if (node_count > CNT_W'(MAX_NODES)) begin
      n_sel = CNT_W'(MAX_NODES);
    end else begin
      n_sel = node_count;
    end
  end

  assign n_last = ROW_W'(n_act - CNT_W'(1));

  // Adjacency memory: one write port from the input, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      adj_mem[row_index[AW-1:0]] <= row_bits;
    end
  end

  always_comb begin
    unique case (state)
      S_RDI:   rd_addr = i[AW-1:0];
      S_LATI:  rd_addr = '0;
      default: rd_addr = k[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    rd_data <= adj_mem[rd_addr];
  end

  // Pair unit: both directions of the friend-of-friend test for (i, kd).
  assign rk       = rd_data & mask;
  assign common   = ri & rk;
  assign onehot_i = BITS_W'(1) << i;
  assign onehot_k = BITS_W'(1) << kd;
  assign t_ik     = (kd != i) && !ri[kd] && (|(common & ~onehot_i));
  assign t_ki     = (kd != i) && !rk[i]  && (|(common & ~onehot_k));

  // Sequencer control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pv    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc && last_row) begin
            state <= S_RDI;
          end
        end
        S_RDI: begin
          state <= S_LATI;
        end
        S_LATI: begin
          pv    <= 1'b1;
          state <= S_SWEEP;
        end
        S_SWEEP: begin
          pv <= (k < n_act);
          if (pv && (kd == n_last)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_acc) begin
            state <= (i == n_last) ? S_IDLE : S_RDI;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers: row pointers, held row i, result accumulator.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_acc && last_row) begin
          n_act <= n_sel;
          mask  <= ~({BITS_W{1'b1}} << n_sel);
          i     <= '0;
        end
      end
      S_RDI: begin
      end
      S_LATI: begin
        ri  <= rd_data & mask;
        acc <= '0;
        kd  <= '0;
        k   <= CNT_W'(1);
      end
      S_SWEEP: begin
        if (pv) begin
          acc[kd] <= t_ik | t_ki;
        end
        kd <= k[ROW_W-1:0];
        k  <= k + CNT_W'(1);
      end
      S_EMIT: begin
        if (out_acc) begin
          i <= i + ROW_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready      = (state == S_IDLE);
  assign out_valid     = (state == S_EMIT);
  assign out_row_index = i;
  assign out_row_bits  = acc;
  assign last_out      = (i == n_last);

endmodule

// ===== design/thnm_checker.sv =====
module thnm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         last_row,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [thnm_pkg::ROW_W-1:0]   out_row_index,
  input logic [thnm_pkg::BITS_W-1:0]  out_row_bits,
  input logic                         last_out
);
  import thnm_pkg::*;

  // The block never takes an item while a result row is pending.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid high together");

  // A stalled result row holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_row_bits)
      && $stable(out_row_index) && $stable(last_out))
    else $error("stalled result row changed");

  // The last row starts the computation; no result appears at once.
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_row |=> !in_ready && !out_valid)
    else $error("last row did not start computation");

  // More result rows follow a row that is not flagged last.
  a_more: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_out |=> !in_ready)
    else $error("input reopened before final result row");

  // Taking the final result row returns the block to idle.
  a_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_out |=> in_ready && !out_valid)
    else $error("block not idle after final result row");

endmodule

bind two_hop_nonneighbor_matrix thnm_checker u_thnm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .last_row      (last_row),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_row_index (out_row_index),
  .out_row_bits  (out_row_bits),
  .last_out      (last_out)
);

// ===== verif/testbench.sv =====
module testbench;
  import thnm_pkg::*;

  localparam int NODES = 64;

  // One row item as it crosses either channel.
  typedef struct {
    logic [ROW_W-1:0]  idx;
    logic [BITS_W-1:0] bits;
    logic              last;
  } row_item_t;

  // Predicts suggestion rows from the loaded adjacency rows and checks the
  // rows the block sends back against them in order.
  class suggestion_board;
    logic [BITS_W-1:0] adj_rows [NODES];
    logic [CNT_W-1:0]  node_cnt;
    row_item_t         expected_rows [$];
    int                errors;

    function new();
      node_cnt = 7'd64;
      errors = 0;
      foreach (adj_rows[i]) adj_rows[i] = '0;
    endfunction

    // Zero nodes behaves as one, and anything past the store size is clamped.
    function int active_nodes();
      int n;
      n = int'(node_cnt);
      if (n == 0) n = 1;
      if (n > NODES) n = NODES;
      return n;
    endfunction

    function int pending();
      return expected_rows.size();
    endfunction

    // Store the row; a last row triggers the friend-of-friend computation.
    function void note_row(row_item_t item);
      int n;
      logic [BITS_W-1:0] mask;
      logic [BITS_W-1:0] two_hop [NODES];
      logic [BITS_W-1:0] ri;
      logic [BITS_W-1:0] via;
      logic [BITS_W-1:0] row;
      row_item_t e;
      adj_rows[item.idx] = item.bits;
      if (!item.last) return;
      n = active_nodes();
      mask = (n == NODES) ? '1 : ((64'd1 << n) - 64'd1);
      foreach (two_hop[i]) two_hop[i] = '0;
      // Node k is suggested for i when it is not i, not a neighbor of i,
      // and shares a neighbor j other than i itself.
      for (int i = 0; i < n; i++) begin
        ri = adj_rows[i] & mask;
        via = ri;
        via[i] = 1'b0;
        row = '0;
        for (int k = 0; k < n; k++) begin
          if (k != i && !ri[k] && ((via & adj_rows[k] & mask) != '0)) row[k] = 1'b1;
        end
        two_hop[i] = row;
      end
      // The result is the relation made symmetric.
      for (int i = 0; i < n; i++) begin
        row = two_hop[i];
        for (int k = 0; k < n; k++) begin
          if (two_hop[k][i]) row[k] = 1'b1;
        end
        e.idx = ROW_W'(i);
        e.bits = row & mask;
        e.last = (i == n - 1);
        expected_rows.insert(expected_rows.size(), e);
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Compare one returned row with the oldest prediction.
    task check_row(row_item_t got);
      row_item_t want;
      if (expected_rows.size() == 0) begin
        report($sformatf("result row %0d arrived with nothing predicted", got.idx));
        return;
      end
      want = expected_rows.pop_front();
      if (got.idx !== want.idx)
        report($sformatf("out_row_index %0d, predicted %0d", got.idx, want.idx));
      if (got.bits !== want.bits)
        report($sformatf("row %0d out_row_bits %h, predicted %h", want.idx, got.bits,
                         want.bits));
      if (got.last !== want.last)
        report($sformatf("row %0d last_out %0b, predicted %0b", want.idx, got.last,
                         want.last));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [CNT_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [ROW_W-1:0]   row_index;
  logic [BITS_W-1:0]  row_bits;
  logic               last_row;
  logic               out_valid;
  logic               out_ready;
  logic [ROW_W-1:0]   out_row_index;
  logic [BITS_W-1:0]  out_row_bits;
  logic               last_out;

  suggestion_board board = new();
  logic [NODES-1:0] written_rows = '0;
  int items_sent = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_phase = 0;
  int bigs;
  int phase_graphs;
  int pick;

  two_hop_nonneighbor_matrix u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .row_index    (row_index),
    .row_bits     (row_bits),
    .last_row     (last_row),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_row_index(out_row_index),
    .out_row_bits (out_row_bits),
    .last_out     (last_out)
  );

  always #5 clk = ~clk;

  // Receiver: check each accepted row, then pick the next ready value from
  // a stall pattern whose mode is redrawn whenever its random run length runs out.
  always @(posedge clk) begin
    row_item_t got;
    if (!rst && out_valid && out_ready) begin
      got.idx = out_row_index;
      got.bits = out_row_bits;
      got.last = last_out;
      board.check_row(got);
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 120);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ((stall_phase % 4) == 0);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Sender: items go out in bursts with idle gaps of random length between.
  task automatic send_row(input logic [ROW_W-1:0] idx, input logic [BITS_W-1:0] bits,
                          input logic last);
    int gap;
    row_item_t item;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    row_index <= idx;
    row_bits <= bits;
    last_row <= last;
    do @(posedge clk); while (!in_ready);
    item.idx = idx;
    item.bits = bits;
    item.last = last;
    board.note_row(item);
    written_rows[idx] = 1'b1;
    items_sent++;
  endtask

  // Let every predicted row come back, then idle on for a trailing store.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.node_cnt = value;
  endtask

  function automatic logic [BITS_W-1:0] random_bits(input int density);
    logic [BITS_W-1:0] a;
    logic [BITS_W-1:0] b;
    logic [BITS_W-1:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case (density)
      0: return a & b & c;
      1: return a & b;
      2: return a;
      default: return a | b;
    endcase
  endfunction

  // Load one graph and end it with a last row. Every row that the
  // computation reads is written first; rows already loaded may be reused.
  task automatic load_graph(input bit full);
    int n;
    int density;
    int tmp;
    int noise;
    int order [$];
    n = board.active_nodes();
    density = $urandom_range(0, 3);
    for (int r = 0; r < n; r++) begin
      if (full || !written_rows[r] || $urandom_range(0, 2) == 0)
        order.insert(order.size(), r);
    end
    if (order.size() == 0) order.insert(0, $urandom_range(0, n - 1));
    for (int j = order.size() - 1; j > 0; j--) begin
      pick = $urandom_range(0, j);
      tmp = order[j];
      order[j] = order[pick];
      order[pick] = tmp;
    end
    // Stray rows anywhere in the sequence, and sometimes an out-of-range
    // row that carries the last flag.
    noise = $urandom_range(0, 3);
    for (int q = 0; q < noise; q++)
      order.insert($urandom_range(0, order.size()), $urandom_range(0, NODES - 1));
    if (n < NODES && $urandom_range(0, 3) == 0)
      order.insert(order.size(), $urandom_range(n, NODES - 1));
    for (int p = 0; p < order.size(); p++)
      send_row(ROW_W'(order[p]), random_bits(density), p == order.size() - 1);
  endtask

  task automatic run_phase(input logic [CNT_W-1:0] count, input int graphs,
                           input bit full);
    wait_idle();
    write_count(count);
    repeat (graphs) load_graph(full);
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    row_index <= '0;
    row_bits <= '0;
    last_row <= 1'b0;
    out_ready <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Zero nodes acts as one node; a self loop and stray high bits count for nothing.
    write_count(7'd0);
    send_row(6'd0, '1, 1'b1);

    // Three nodes sharing a hub, with the last flag on an out-of-range row.
    wait_idle();
    write_count(7'd3);
    send_row(6'd0, 64'h0000_0000_0000_0006, 1'b0);
    send_row(6'd1, 64'hA5A5_0000_0000_0001, 1'b0);
    send_row(6'd2, 64'h8000_0000_0000_0001, 1'b0);
    send_row(6'd63, '0, 1'b1);

    // A one-way chain: rows are used exactly as given.
    wait_idle();
    write_count(7'd4);
    send_row(6'd0, 64'h2, 1'b0);
    send_row(6'd1, 64'h4, 1'b0);
    send_row(6'd2, 64'h0, 1'b0);
    send_row(6'd3, 64'h5, 1'b1);

    // Two nodes, one empty row and one full row.
    wait_idle();
    write_count(7'd2);
    send_row(6'd0, '0, 1'b0);
    send_row(6'd1, '1, 1'b1);

    // A single node again, written through the register.
    wait_idle();
    write_count(7'd1);
    send_row(6'd0, 64'h1, 1'b1);

    // Full load above the store size, then a partial reload at exactly 64.
    run_phase(7'd127, 1, 1'b1);
    run_phase(7'd64, 1, 1'b0);

    // Mostly small graphs, with a rare large one.
    bigs = 0;
    while (items_sent < 160) begin
      pick = $urandom_range(0, 9);
      phase_graphs = $urandom_range(1, 3);
      if (pick == 0 && bigs < 2) begin
        bigs++;
        run_phase(CNT_W'($urandom_range(11, 127)), 1, 1'($urandom_range(0, 1)));
      end else if (pick == 1) begin
        run_phase(CNT_W'($urandom_range(0, 1)), phase_graphs, 1'($urandom_range(0, 1)));
      end else begin
        run_phase(CNT_W'($urandom_range(2, 10)), phase_graphs, 1'($urandom_range(0, 1)));
      end
    end

    wait_idle();
    if (board.errors == 0) begin
      $display("[two_hop_nonneighbor_matrix] OK");
    end else begin
      $display("[two_hop_nonneighbor_matrix] ERROR");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #50000000;
    $display("[two_hop_nonneighbor_matrix] ERROR");
    $finish;
  end

endmodule
